// File: design/pts_pkg.sv
// pts_pkg: shared types and codes for the priority task scheduler
// no dependencies; used by every design file

package pts_pkg;

    // command opcodes
    localparam logic [2:0] OP_CREATE  = 3'd0;
    localparam logic [2:0] OP_WAIT    = 3'd1;
    localparam logic [2:0] OP_WAITPID = 3'd2;
    localparam logic [2:0] OP_KILL    = 3'd3;
    localparam logic [2:0] OP_EXIT    = 3'd4;
    localparam logic [2:0] OP_TICK    = 3'd5;

    // result status codes
    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_FULL     = 2'd1;
    localparam logic [1:0] STAT_NOTFOUND = 2'd2;
    localparam logic [1:0] STAT_NORUN    = 2'd3;

    // task states
    localparam logic [1:0] TS_READY   = 2'd0;
    localparam logic [1:0] TS_RUNNING = 2'd1;
    localparam logic [1:0] TS_WAITING = 2'd2;
    localparam logic [1:0] TS_DONE    = 2'd3;

    // widest level field (up to 16 levels)
    localparam int LVL_W = 4;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [15:0] priority_req;
        logic [15:0] quanta;
        logic [15:0] target_id;
    } pts_in_t;

    typedef struct packed {
        logic [15:0] running_id;
        logic        running_valid;
        logic [15:0] created_id;
        logic [1:0]  status;
    } pts_out_t;

    // classified command held in the queue
    typedef struct packed {
        logic [2:0]       opcode;
        logic [LVL_W-1:0] level;
        logic [15:0]      sleep;
        logic [15:0]      target_id;
    } pts_cmd_t;

endpackage

// File: design/priority_task_scheduler.sv
// priority_task_scheduler: fixed-priority task table driven by command words
// create and kill scan the table slot by slot; wait, waitpid and tick run an
// election that scans each level with the one-slot-per-cycle scan; exit and unused
// opcodes go straight to the result; a command is issued from the queue, tick then
// counts down sleeping tasks, and the result word is posted from a register
// throughput: one command at a time in the engine, two more queue in front
// reset: table empty, next id one, no running task; depends on pts_pkg

module priority_task_scheduler
    import pts_pkg::*;
#(
    parameter int MAX_TASKS       = 16,
    parameter int PRIORITY_LEVELS = 4
) (
    input  logic     clk,
    input  logic     rst_n,
    // command words
    input  logic     cmd_valid,
    output logic     cmd_stall,
    input  pts_in_t  cmd,
    // result words
    output logic     rsp_valid,
    input  logic     rsp_stall,
    output pts_out_t rsp
);

    // queue between front and engine
    logic     q_valid;
    logic     q_take;
    pts_cmd_t q_word;

    // front: accepts words, clamps the level and the sleep count
    pts_front #(
        .PRIORITY_LEVELS(PRIORITY_LEVELS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd_valid(cmd_valid),
        .cmd_stall(cmd_stall),
        .cmd      (cmd),
        .q_valid  (q_valid),
        .q_take   (q_take),
        .q_word   (q_word)
    );

    // engine: task table, election scan, countdown, result register
    pts_engine #(
        .MAX_TASKS      (MAX_TASKS),
        .PRIORITY_LEVELS(PRIORITY_LEVELS)
    ) u_engine (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_take   (q_take),
        .q_word   (q_word),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp      (rsp)
    );

endmodule

// File: design/pts_front.sv
// pts_front: accepts command words, clamps level and sleep count,
// and holds them in a two-entry queue; depends on pts_pkg

module pts_front
    import pts_pkg::*;
#(
    parameter int PRIORITY_LEVELS = 4
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     cmd_valid,
    output logic     cmd_stall,
    input  pts_in_t  cmd,
    output logic     q_valid,
    input  logic     q_take,
    output pts_cmd_t q_word
);

    pts_cmd_t   mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    pts_cmd_t   cls;
    logic       push, pop;

    always_comb
    begin
        cls.opcode    = cmd.opcode;
        cls.target_id = cmd.target_id;
        cls.sleep     = (cmd.quanta == 16'd0) ? 16'd1 : cmd.quanta;
        if (cmd.priority_req >= 16'(PRIORITY_LEVELS))
            cls.level = LVL_W'(PRIORITY_LEVELS - 1);
        else
            cls.level = cmd.priority_req[LVL_W-1:0];
    end

    assign cmd_stall = (count_reg == 2'd2);
    assign q_valid   = (count_reg != 2'd0);
    assign q_word    = mem_reg[rd_ptr_reg];
    assign push      = cmd_valid && !cmd_stall;
    assign pop       = q_take && q_valid;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= cls;
    end

endmodule

// File: design/pts_engine.sv
// pts_engine: task table and the sequencer that carries out commands,
// elections and countdown, plus the result register; depends on pts_pkg

module pts_engine
    import pts_pkg::*;
#(
    parameter int MAX_TASKS       = 16,
    parameter int PRIORITY_LEVELS = 4
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     q_valid,
    output logic     q_take,
    input  pts_cmd_t q_word,
    output logic     rsp_valid,
    input  logic     rsp_stall,
    output pts_out_t rsp
);

    localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int LW = (PRIORITY_LEVELS > 1) ? $clog2(PRIORITY_LEVELS) : 1;
    localparam int KW = 16 + IW;
    localparam logic [IW-1:0] LAST_IDX = IW'(MAX_TASKS - 1);
    localparam logic [LW-1:0] TOP_LVL  = LW'(PRIORITY_LEVELS - 1);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_FREE  = 4'd1;
    localparam logic [3:0] S_KILL  = 4'd2;
    localparam logic [3:0] S_HEAD  = 4'd3;
    localparam logic [3:0] S_NEXT  = 4'd4;
    localparam logic [3:0] S_VISIT = 4'd5;
    localparam logic [3:0] S_VHEAD = 4'd6;
    localparam logic [3:0] S_COUNT = 4'd7;
    localparam logic [3:0] S_DONE  = 4'd8;

    // task table
    logic [MAX_TASKS-1:0] used_reg;
    logic [15:0]          id_mem     [MAX_TASKS];
    logic [LW-1:0]        level_mem  [MAX_TASKS];
    logic [1:0]           tstat_mem  [MAX_TASKS];
    logic [15:0]          sleep_mem  [MAX_TASKS];
    logic [15:0]          target_mem [MAX_TASKS];
    logic                 onid_mem   [MAX_TASKS];
    logic [15:0]          order_mem  [MAX_TASKS];

    // sequencer state
    logic [3:0]    state_reg, state_next;
    pts_cmd_t      cmd_reg, cmd_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic [LW-1:0] lv_reg, lv_next;
    logic [KW-1:0] cur_reg, cur_next;
    logic [KW-1:0] best_reg, best_next;
    logic          have_reg, have_next;
    logic [IW-1:0] sel_reg, sel_next;
    logic [IW-1:0] head_reg, head_next;
    logic [IW-1:0] run_reg, run_next;
    logic          present_reg, present_next;
    logic [15:0]   nid_reg, nid_next;
    logic [15:0]   ocnt_reg, ocnt_next;
    logic [15:0]   created_reg, created_next;
    logic [1:0]    status_reg, status_next;
    logic          rsp_valid_reg, rsp_valid_next;
    pts_out_t      rsp_reg;

    // table write controls
    logic          st_en;
    logic [IW-1:0] st_slot;
    logic [1:0]    st_val;
    logic          new_en;
    logic          wait_en;
    logic          rec_en;
    logic [IW-1:0] rec_slot;
    logic          clr_en;
    logic [IW-1:0] clr_slot;
    logic          cnt_en;
    logic          rsp_load;

    // scan helpers
    logic [KW-1:0] key_i;
    logic          cand;
    logic          take_i;
    logic          have_n;
    logic [KW-1:0] best_n;
    logic [IW-1:0] sel_n;
    logic          last_i;
    logic [IW-1:0] vs;
    logic [15:0]   nid_inc;

    assign key_i  = {order_mem[idx_reg], idx_reg};
    assign last_i = (idx_reg == LAST_IDX);
    assign nid_inc = nid_reg + 16'd1;

    always_comb
    begin
        cand = used_reg[idx_reg] && (level_mem[idx_reg] == lv_reg);
        if (state_reg == S_NEXT)
            cand = cand && (key_i > cur_reg);
        take_i = cand && (!have_reg || key_i < best_reg);
        have_n = have_reg || take_i;
        best_n = take_i ? key_i : best_reg;
        sel_n  = take_i ? idx_reg : sel_reg;
    end

    assign q_take    = (state_reg == S_IDLE) && q_valid;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        idx_next       = idx_reg;
        lv_next        = lv_reg;
        cur_next       = cur_reg;
        best_next      = best_reg;
        have_next      = have_reg;
        sel_next       = sel_reg;
        head_next      = head_reg;
        run_next       = run_reg;
        present_next   = present_reg;
        nid_next       = nid_reg;
        ocnt_next      = ocnt_reg;
        created_next   = created_reg;
        status_next    = status_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        st_en    = 1'b0;
        st_slot  = run_reg;
        st_val   = TS_READY;
        new_en   = 1'b0;
        wait_en  = 1'b0;
        rec_en   = 1'b0;
        rec_slot = head_reg;
        clr_en   = 1'b0;
        clr_slot = idx_reg;
        cnt_en   = 1'b0;
        rsp_load = 1'b0;
        vs       = (state_reg == S_VHEAD) ? head_reg : sel_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    cmd_next     = q_word;
                    created_next = 16'd0;
                    status_next  = STAT_OK;
                    idx_next     = '0;
                    have_next    = 1'b0;
                    lv_next      = TOP_LVL;
                    case (q_word.opcode)
                        OP_CREATE: state_next = S_FREE;
                        OP_KILL:   state_next = S_KILL;
                        OP_WAIT, OP_WAITPID, OP_EXIT:
                        begin
                            if (!present_reg)
                            begin
                                status_next = STAT_NORUN;
                                state_next  = S_DONE;
                            end
                            else if (q_word.opcode == OP_EXIT)
                            begin
                                st_en        = 1'b1;
                                st_val       = TS_DONE;
                                present_next = 1'b0;
                                state_next   = S_DONE;
                            end
                            else
                            begin
                                // sleep the running task, then elect
                                st_en        = 1'b1;
                                st_val       = TS_WAITING;
                                wait_en      = 1'b1;
                                present_next = 1'b0;
                                state_next   = S_HEAD;
                            end
                        end
                        OP_TICK:
                        begin
                            if (present_reg && tstat_mem[run_reg] == TS_RUNNING)
                            begin
                                st_en  = 1'b1;
                                st_val = TS_READY;
                            end
                            present_next = 1'b0;
                            state_next   = S_HEAD;
                        end
                        default: state_next = S_DONE;
                    endcase
                end
            end

            S_FREE:
            begin
                if (!used_reg[idx_reg])
                begin
                    new_en       = 1'b1;
                    created_next = nid_reg;
                    nid_next     = (nid_inc == 16'd0) ? 16'd1 : nid_inc;
                    ocnt_next    = ocnt_reg + 16'd1;
                    state_next   = S_DONE;
                end
                else if (last_i)
                begin
                    status_next = STAT_FULL;
                    state_next  = S_DONE;
                end
                else
                    idx_next = idx_reg + IW'(1);
            end

            S_KILL:
            begin
                if (used_reg[idx_reg] && id_mem[idx_reg] == cmd_reg.target_id)
                begin
                    clr_en = 1'b1;
                    if (present_reg && run_reg == idx_reg)
                        present_next = 1'b0;
                    state_next = S_DONE;
                end
                else if (last_i)
                begin
                    status_next = STAT_NOTFOUND;
                    state_next  = S_DONE;
                end
                else
                    idx_next = idx_reg + IW'(1);
            end

            S_HEAD, S_NEXT:
            begin
                have_next = have_n;
                best_next = best_n;
                sel_next  = sel_n;
                if (!last_i)
                    idx_next = idx_reg + IW'(1);
                else
                begin
                    idx_next  = '0;
                    have_next = 1'b0;
                    if (state_reg == S_HEAD)
                    begin
                        if (have_n)
                        begin
                            cur_next   = best_n;
                            head_next  = sel_n;
                            state_next = S_NEXT;
                        end
                        else if (lv_reg == '0)
                            state_next = (cmd_reg.opcode == OP_TICK) ? S_COUNT : S_DONE;
                        else
                            lv_next = lv_reg - LW'(1);
                    end
                    else if (have_n)
                    begin
                        cur_next   = best_n;
                        state_next = S_VISIT;
                    end
                    else
                        state_next = S_VHEAD;
                end
            end

            S_VISIT, S_VHEAD:
            begin
                idx_next  = '0;
                have_next = 1'b0;
                if ((state_reg == S_VHEAD) && !used_reg[vs])
                begin
                    if (lv_reg == '0)
                        state_next = (cmd_reg.opcode == OP_TICK) ? S_COUNT : S_DONE;
                    else
                    begin
                        lv_next    = lv_reg - LW'(1);
                        state_next = S_HEAD;
                    end
                end
                else if (tstat_mem[vs] == TS_READY || tstat_mem[vs] == TS_RUNNING)
                begin
                    st_en        = 1'b1;
                    st_slot      = vs;
                    st_val       = TS_RUNNING;
                    run_next     = vs;
                    present_next = 1'b1;
                    state_next   = (cmd_reg.opcode == OP_TICK) ? S_COUNT : S_DONE;
                end
                else
                begin
                    if (tstat_mem[vs] == TS_DONE)
                    begin
                        // reclaim and wake waiters on its id
                        rec_en   = 1'b1;
                        rec_slot = vs;
                        clr_en   = 1'b1;
                        clr_slot = vs;
                    end
                    if (state_reg == S_VISIT)
                        state_next = S_NEXT;
                    else if (lv_reg == '0)
                        state_next = (cmd_reg.opcode == OP_TICK) ? S_COUNT : S_DONE;
                    else
                    begin
                        lv_next    = lv_reg - LW'(1);
                        state_next = S_HEAD;
                    end
                end
            end

            S_COUNT:
            begin
                cnt_en     = 1'b1;
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_load       = 1'b1;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            lv_reg        <= '0;
            have_reg      <= 1'b0;
            run_reg       <= '0;
            present_reg   <= 1'b0;
            nid_reg       <= 16'd1;
            ocnt_reg      <= 16'd0;
            rsp_valid_reg <= 1'b0;
            used_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            lv_reg        <= lv_next;
            have_reg      <= have_next;
            run_reg       <= run_next;
            present_reg   <= present_next;
            nid_reg       <= nid_next;
            ocnt_reg      <= ocnt_next;
            rsp_valid_reg <= rsp_valid_next;
            if (new_en)
                used_reg[idx_reg] <= 1'b1;
            if (clr_en)
                used_reg[clr_slot] <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        cur_reg     <= cur_next;
        best_reg    <= best_next;
        sel_reg     <= sel_next;
        head_reg    <= head_next;
        created_reg <= created_next;
        status_reg  <= status_next;
        if (rsp_load)
        begin
            rsp_reg.running_valid <= present_reg;
            rsp_reg.running_id    <= present_reg ? id_mem[run_reg] : 16'd0;
            rsp_reg.created_id    <= created_reg;
            rsp_reg.status        <= status_reg;
        end
    end

    // table payload, per-slot updates
    always_ff @(posedge clk)
    begin
        for (int j = 0; j < MAX_TASKS; j++)
        begin
            if (rec_en && used_reg[j] && tstat_mem[j] == TS_WAITING && onid_mem[j]
                && target_mem[j] == id_mem[rec_slot])
            begin
                tstat_mem[j] <= TS_READY;
                onid_mem[j]  <= 1'b0;
            end
            if (cnt_en && used_reg[j] && tstat_mem[j] == TS_WAITING && !onid_mem[j])
            begin
                if (sleep_mem[j] <= 16'd1)
                begin
                    sleep_mem[j] <= 16'd0;
                    tstat_mem[j] <= TS_READY;
                end
                else
                    sleep_mem[j] <= sleep_mem[j] - 16'd1;
            end
        end
        if (st_en)
            tstat_mem[st_slot] <= st_val;
        // wait is issued straight from the queue head
        if (wait_en)
        begin
            if (q_word.opcode == OP_WAIT)
            begin
                sleep_mem[run_reg] <= q_word.sleep;
                onid_mem[run_reg]  <= 1'b0;
            end
            else
            begin
                target_mem[run_reg] <= q_word.target_id;
                onid_mem[run_reg]   <= 1'b1;
            end
        end
        if (new_en)
        begin
            id_mem[idx_reg]     <= nid_reg;
            level_mem[idx_reg]  <= cmd_reg.level[LW-1:0];
            tstat_mem[idx_reg]  <= TS_READY;
            sleep_mem[idx_reg]  <= 16'd0;
            target_mem[idx_reg] <= 16'd0;
            onid_mem[idx_reg]   <= 1'b0;
            order_mem[idx_reg]  <= ocnt_reg;
        end
    end

endmodule

// File: tb/tb.sv
// tb: self-checking testbench for priority_task_scheduler
// depends on pts_pkg and the scheduler rtl; holds its own model of the task table
`timescale 1ns / 100ps

module tb;
    import pts_pkg::*;

    localparam int NSLOT    = 16;
    localparam int NLVL     = 4;
    localparam int N_RANDOM = 1150;
    localparam int LIMIT    = 4000000;

    // scoreboard: software copy of the task table and the queue of expected words
    class sched_scoreboard;
        bit        used [NSLOT];
        bit [15:0] tid [NSLOT];
        bit [1:0]  lvl [NSLOT];
        bit [1:0]  tst [NSLOT];
        bit [15:0] slp [NSLOT];
        bit [15:0] wtgt [NSLOT];
        bit        on_id [NSLOT];
        bit [15:0] ord [NSLOT];
        bit [15:0] next_id;
        bit [15:0] ord_cnt;
        int        run_slot;
        bit        run_on;
        pts_out_t  pending [$];
        int        errors;

        function new();
            foreach (used[i]) used[i] = 0;
            next_id = 1;
            ord_cnt = 0;
            run_slot = 0;
            run_on = 0;
            errors = 0;
        endfunction

        function bit [24:0] okey(int s);
            return {ord[s], 9'(s)};
        endfunction

        function void reclaim(int s);
            bit [15:0] gone;
            gone = tid[s];
            used[s] = 0;
            if (run_on && run_slot == s) run_on = 0;
            for (int j = 0; j < NSLOT; j++)
                if (used[j] && tst[j] == TS_WAITING && on_id[j] && wtgt[j] == gone)
                begin
                    tst[j] = TS_READY;
                    on_id[j] = 0;
                end
        endfunction

        // terminated tasks are reclaimed on the way; ready ones win
        function bit pick(int s);
            if (tst[s] == TS_DONE)
            begin
                reclaim(s);
                return 0;
            end
            if (tst[s] == TS_WAITING) return 0;
            tst[s] = TS_RUNNING;
            run_slot = s;
            run_on = 1;
            return 1;
        endfunction

        function void elect();
            bit        found;
            bit        have;
            int        head;
            int        nxt;
            bit [24:0] cur;
            bit [24:0] best;
            if (run_on && tst[run_slot] == TS_RUNNING) tst[run_slot] = TS_READY;
            run_on = 0;
            for (int lv = NLVL - 1; lv >= 0; lv--)
            begin
                found = 0;
                head = 0;
                cur = 0;
                for (int j = 0; j < NSLOT; j++)
                    if (used[j] && lvl[j] == lv && (!found || okey(j) < cur))
                    begin
                        found = 1;
                        head = j;
                        cur = okey(j);
                    end
                if (!found) continue;
                // second oldest onward, oldest last
                forever
                begin
                    have = 0;
                    nxt = 0;
                    best = 0;
                    for (int j = 0; j < NSLOT; j++)
                        if (used[j] && lvl[j] == lv && okey(j) > cur &&
                            (!have || okey(j) < best))
                        begin
                            have = 1;
                            nxt = j;
                            best = okey(j);
                        end
                    if (!have) break;
                    cur = best;
                    if (pick(nxt)) return;
                end
                if (used[head] && pick(head)) return;
            end
        endfunction

        function void countdown();
            for (int j = 0; j < NSLOT; j++)
                if (used[j] && tst[j] == TS_WAITING && !on_id[j])
                begin
                    if (slp[j] <= 16'd1)
                    begin
                        slp[j] = 0;
                        tst[j] = TS_READY;
                    end
                    else
                        slp[j] = slp[j] - 16'd1;
                end
        endfunction

        function void note_command(pts_in_t c);
            pts_out_t r;
            int       s;
            bit       hit;
            r = '0;
            r.status = STAT_OK;
            case (c.opcode)
                OP_CREATE:
                begin
                    s = -1;
                    for (int j = 0; j < NSLOT; j++)
                        if (s < 0 && !used[j]) s = j;
                    if (s < 0)
                        r.status = STAT_FULL;
                    else
                    begin
                        r.created_id = next_id;
                        next_id = next_id + 16'd1;
                        if (next_id == 0) next_id = 1;
                        used[s] = 1;
                        tid[s] = r.created_id;
                        lvl[s] = (c.priority_req >= 16'(NLVL)) ? 2'(NLVL - 1)
                                                                 : c.priority_req[1:0];
                        tst[s] = TS_READY;
                        slp[s] = 0;
                        wtgt[s] = 0;
                        on_id[s] = 0;
                        ord[s] = ord_cnt;
                        ord_cnt = ord_cnt + 16'd1;
                    end
                end
                OP_WAIT, OP_WAITPID, OP_EXIT:
                begin
                    if (!run_on)
                        r.status = STAT_NORUN;
                    else if (c.opcode == OP_EXIT)
                    begin
                        tst[run_slot] = TS_DONE;
                        run_on = 0;
                    end
                    else
                    begin
                        tst[run_slot] = TS_WAITING;
                        if (c.opcode == OP_WAIT)
                        begin
                            slp[run_slot] = (c.quanta == 0) ? 16'd1 : c.quanta;
                            on_id[run_slot] = 0;
                        end
                        else
                        begin
                            wtgt[run_slot] = c.target_id;
                            on_id[run_slot] = 1;
                        end
                        elect();
                    end
                end
                OP_KILL:
                begin
                    hit = 0;
                    for (int j = 0; j < NSLOT; j++)
                        if (!hit && used[j] && tid[j] == c.target_id)
                        begin
                            hit = 1;
                            used[j] = 0;
                            if (run_on && run_slot == j) run_on = 0;
                        end
                    if (!hit) r.status = STAT_NOTFOUND;
                end
                OP_TICK:
                begin
                    elect();
                    countdown();
                end
                default: ;
            endcase
            if (run_on)
            begin
                r.running_id = tid[run_slot];
                r.running_valid = 1;
            end
            pending.push_back(r);
        endfunction

        function void check_result(pts_out_t got);
            pts_out_t want;
            if (pending.size() == 0)
            begin
                report("unexpected result word");
                return;
            end
            want = pending.pop_front();
            if (got.running_id !== want.running_id)
                report($sformatf("running_id got %0d want %0d",
                                 got.running_id, want.running_id));
            if (got.running_valid !== want.running_valid)
                report($sformatf("running_valid got %b want %b",
                                 got.running_valid, want.running_valid));
            if (got.created_id !== want.created_id)
                report($sformatf("created_id got %0d want %0d",
                                 got.created_id, want.created_id));
            if (got.status !== want.status)
                report($sformatf("status got %0d want %0d", got.status, want.status));
        endfunction

        function void report(string msg);
            errors++;
            if (errors <= 50) $display("mismatch @%0t: %s", $realtime, msg);
        endfunction
    endclass

    logic     clk = 0;
    logic     rst_n = 0;
    logic     cmd_valid = 0;
    logic     cmd_stall;
    pts_in_t  cmd = '0;
    logic     rsp_valid;
    logic     rsp_stall = 0;
    pts_out_t rsp;

    int send_idle = 0;   // percent of cycles the sender idles
    int recv_idle = 0;   // percent of cycles the receiver stalls
    int cycles = 0;
    sched_scoreboard sb;

    priority_task_scheduler dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always #5 clk = ~clk;

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // result side: random stall, check each accepted word
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall) sb.check_result(rsp);
        rsp_stall <= ($urandom_range(99) < recv_idle);
    end

    // one command word; idles before it, holds it until accepted
    task automatic send_word(pts_in_t c);
        while ($urandom_range(99) < send_idle)
        begin
            cmd_valid <= 0;
            @(posedge clk);
        end
        cmd_valid <= 1;
        cmd <= c;
        @(posedge clk);
        while (cmd_stall) @(posedge clk);
        sb.note_command(c);
    endtask

    task automatic send_op(logic [2:0] op, logic [15:0] p, logic [15:0] q,
                           logic [15:0] t);
        pts_in_t c;
        c.opcode = op;
        c.priority_req = p;
        c.quanta = q;
        c.target_id = t;
        send_word(c);
    endtask

    // random id near the live ones so kill and waitpid usually hit
    function automatic logic [15:0] some_id();
        if ($urandom_range(9) == 0) return 16'($urandom);
        return sb.next_id - 16'($urandom_range(1, 20));
    endfunction

    task automatic send_random();
        int k;
        logic [2:0] op;
        k = $urandom_range(99);
        if (k < 22) op = OP_CREATE;
        else if (k < 40) op = OP_WAIT;
        else if (k < 52) op = OP_WAITPID;
        else if (k < 62) op = OP_KILL;
        else if (k < 72) op = OP_EXIT;
        else if (k < 97) op = OP_TICK;
        else op = 3'($urandom_range(6, 7));
        send_op(op,
                ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(4)),
                ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(4)),
                some_id());
    endtask

    initial
    begin
        sb = new();
        repeat (11) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: extremes, every opcode, empty table and full table
        send_op(OP_WAIT, 0, 0, 0);            // no running task
        send_op(OP_WAITPID, 0, 0, 0);
        send_op(OP_EXIT, 0, 0, 0);
        send_op(OP_TICK, 0, 0, 0);            // empty election
        send_op(OP_KILL, 0, 0, 16'hffff);     // kill id not found
        send_op(3'd6, 16'hffff, 16'hffff, 16'hffff);
        send_op(3'd7, 0, 0, 0);
        for (int i = 0; i < 17; i++)          // fills table then full
            send_op(OP_CREATE, (i == 0) ? 16'hffff : 16'(i % 5), 0, 0);
        send_op(OP_TICK, 0, 0, 0);
        send_op(OP_WAIT, 0, 16'hffff, 0);
        send_op(OP_TICK, 0, 0, 0);
        send_op(OP_WAITPID, 0, 0, 16'd3);
        send_op(OP_EXIT, 0, 0, 0);
        send_op(OP_TICK, 0, 0, 0);
        send_op(OP_WAIT, 0, 0, 0);            // zero quanta is one
        send_op(OP_KILL, 0, 0, 16'd3);

        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0: begin send_idle = 0;  recv_idle = 0;  end
                1: begin send_idle = 72; recv_idle = 0;  end
                2: begin send_idle = 0;  recv_idle = 72; end
                3: begin send_idle = 6;  recv_idle = 6;  end
                default: begin send_idle = $urandom_range(50); recv_idle = 30; end
            endcase
            for (int i = 0; i < N_RANDOM / 5; i++)
                send_random();
        end
        // id wrap: enough creates to pass 65535 would be too long, so the bench never
        // drives the next id past it

        cmd_valid <= 0;
        send_idle = 0;
        recv_idle = 0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (100) @(posedge clk);
        if (sb.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule

// File: files.f
design/pts_pkg.sv
design/pts_front.sv
design/pts_engine.sv
design/priority_task_scheduler.sv
tb/tb.sv
